// ===== rtl/fmr_pkg.sv =====
// Package for the rounded float multiplier: shared types and constants.
// No dependencies.
`default_nettype none
package fmr_pkg;
   localparam int unsigned SGL_MB = 23;
   localparam int unsigned HLF_MB = 10;

   typedef enum logic [1:0] {
      RND_ZERO = 2'd0,
      RND_NEAR = 2'd1,
      RND_POS  = 2'd2,
      RND_NEG  = 2'd3
   } rnd_type;

   localparam logic CSR_FORMAT   = 1'b0;
   localparam logic CSR_ROUNDING = 1'b1;

   // operands unpacked in stage 1
   typedef struct packed {
      logic          half;
      rnd_type       rnd;
      logic          special;
      logic [31:0]   special_res;
      logic          sign;
      logic [23:0]   ma;
      logic [23:0]   mb;
      logic signed [9:0] base;   // weight of product lsb
   } unp_type;

   // after product
   typedef struct packed {
      logic          half;
      rnd_type       rnd;
      logic          special;
      logic [31:0]   special_res;
      logic          sign;
      logic [47:0]   p;
      logic signed [9:0] base;
   } prd_type;
endpackage
`default_nettype wire

// ===== rtl/fmr_unpack.sv =====
// Stage 1: classify operands, build significands and exponent base.
// Depends on fmr_pkg.
`default_nettype none
module fmr_unpack (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic          half,
   input  wire fmr_pkg::rnd_type rnd,
   input  wire logic [31:0]   operand_a,
   input  wire logic [31:0]   operand_b,
   output fmr_pkg::unp_type   unp_ff
);
   import fmr_pkg::*;
   unp_type unp_in;
   logic [7:0] ea, eb, emask;
   logic [22:0] fa, fb;
   logic sa, sb;
   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic signed [9:0] xa, xb, bias;
   logic [31:0] qbit, emsk_sh, sm;

   always_comb begin
      if (half) begin
         ea = {3'd0, operand_a[14:10]};
         eb = {3'd0, operand_b[14:10]};
         fa = {13'd0, operand_a[9:0]};
         fb = {13'd0, operand_b[9:0]};
         sa = operand_a[15];
         sb = operand_b[15];
         emask = 8'h1f;
         bias = 10'sd15;
         qbit = 32'h200;
         emsk_sh = 32'h7c00;
         sm = 32'h8000;
      end else begin
         ea = operand_a[30:23];
         eb = operand_b[30:23];
         fa = operand_a[22:0];
         fb = operand_b[22:0];
         sa = operand_a[31];
         sb = operand_b[31];
         emask = 8'hff;
         bias = 10'sd127;
         qbit = 32'h400000;
         emsk_sh = 32'h7f800000;
         sm = 32'h80000000;
      end
      a_nan = (ea == emask) && (fa != '0);
      b_nan = (eb == emask) && (fb != '0);
      a_inf = (ea == emask) && (fa == '0);
      b_inf = (eb == emask) && (fb == '0);
      a_zero = (ea == '0) && (fa == '0);
      b_zero = (eb == '0) && (fb == '0);
      unp_in.half = half;
      unp_in.rnd = rnd;
      unp_in.sign = sa ^ sb;
      unp_in.special = 1'b1;
      if (a_nan)
         unp_in.special_res = (half ? {16'd0, operand_a[15:0]} : operand_a) | emsk_sh | qbit;
      else if (b_nan)
         unp_in.special_res = (half ? {16'd0, operand_b[15:0]} : operand_b) | emsk_sh | qbit;
      else if ((a_inf && b_zero) || (b_inf && a_zero))
         unp_in.special_res = sm | emsk_sh | qbit;
      else if (a_inf || b_inf)
         unp_in.special_res = (unp_in.sign ? sm : 32'd0) | emsk_sh;
      else begin
         unp_in.special_res = unp_in.sign ? sm : 32'd0;
         unp_in.special = a_zero || b_zero;
      end
      if (half) begin
         unp_in.ma = {13'd0, (ea != '0), fa[9:0]};
         unp_in.mb = {13'd0, (eb != '0), fb[9:0]};
      end else begin
         unp_in.ma = {(ea != '0), fa};
         unp_in.mb = {(eb != '0), fb};
      end
      xa = (ea != '0) ? ($signed({2'd0, ea}) - bias) : (10'sd1 - bias);
      xb = (eb != '0) ? ($signed({2'd0, eb}) - bias) : (10'sd1 - bias);
      unp_in.base = xa + xb - (half ? 10'sd20 : 10'sd46);
   end

   always_ff @(posedge clock) begin
      if (enable) unp_ff <= unp_in;
   end
endmodule
`default_nettype wire

// ===== rtl/fmr_mult.sv =====
// Stage 2: 24x24 significand product.
// Depends on fmr_pkg.
`default_nettype none
module fmr_mult (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire fmr_pkg::unp_type unp,
   output fmr_pkg::prd_type prd_ff
);
   import fmr_pkg::*;
   prd_type prd_in;
   always_comb begin
      prd_in.half = unp.half;
      prd_in.rnd = unp.rnd;
      prd_in.special = unp.special;
      prd_in.special_res = unp.special_res;
      prd_in.sign = unp.sign;
      prd_in.base = unp.base;
      prd_in.p = unp.ma * unp.mb;
   end
   always_ff @(posedge clock) begin
      if (enable) prd_ff <= prd_in;
   end
endmodule
`default_nettype wire

// ===== rtl/fmr_round.sv =====
// Stages 3 and 4: normalize with guard and sticky, round, pack.
// Depends on fmr_pkg.
`default_nettype none
module fmr_round (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire fmr_pkg::prd_type prd,
   output logic [31:0]      res_ff
);
   import fmr_pkg::*;
   // stage 3: leading one and shift
   logic [5:0]  lz;
   logic signed [10:0] e, er, sh, emin;
   logic [47:0] q;
   logic g, st;
   logic [47:0] lowmask;
   logic [24:0] q_in, q_ff;
   logic g_in, g_ff, st_in, st_ff;
   logic signed [10:0] er_ff;
   logic half_ff, sign_ff, special_ff;
   rnd_type rnd_ff;
   logic [31:0] sres_ff;

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 48; i++)
         if (prd.p[i]) lz = 6'(i);
      e = 11'(prd.base) + $signed({5'd0, lz});
      emin = prd.half ? -11'sd14 : -11'sd126;
      er = (e > emin) ? e : emin;
      sh = er - (prd.half ? 11'sd10 : 11'sd23) - 11'(prd.base);
      q = '0; g = 1'b0; st = 1'b0; lowmask = '0;
      if (sh <= 0)
         q = prd.p << 6'(-sh);
      else if (sh > 11'sd48)
         st = (prd.p != '0);
      else begin
         // a shift of 48 still has the top product bit as guard
         q = prd.p >> 6'(sh);
         g = prd.p[6'(sh - 1)];
         lowmask = (48'd1 << 6'(sh - 1)) - 48'd1;
         st = (prd.p & lowmask) != '0;
      end
      q_in = q[24:0];
      g_in = g;
      st_in = st;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in; g_ff <= g_in; st_ff <= st_in; er_ff <= er;
         half_ff <= prd.half; sign_ff <= prd.sign; special_ff <= prd.special;
         rnd_ff <= prd.rnd; sres_ff <= prd.special_res;
      end
   end

   // stage 4: round and pack
   logic inc, to_inf, nrm;
   logic [24:0] qr;
   logic signed [10:0] ef, be;
   logic [31:0] res_in, sm;
   always_comb begin
      case (rnd_ff)
         RND_NEAR: inc = g_ff && (st_ff || q_ff[0]);
         RND_POS:  inc = !sign_ff && (g_ff || st_ff);
         RND_NEG:  inc = sign_ff && (g_ff || st_ff);
         default:  inc = 1'b0;
      endcase
      qr = q_ff + 25'(inc);
      ef = er_ff;
      if (half_ff ? qr[11] : qr[24]) begin
         qr = qr >> 1;
         ef = ef + 11'sd1;
      end
      be = ef + (half_ff ? 11'sd15 : 11'sd127);
      nrm = half_ff ? qr[10] : qr[23];
      to_inf = (rnd_ff == RND_NEAR) || (rnd_ff == RND_POS && !sign_ff) ||
               (rnd_ff == RND_NEG && sign_ff);
      sm = half_ff ? 32'h8000 : 32'h80000000;
      if (special_ff)
         res_in = sres_ff;
      else if (be >= (half_ff ? 11'sd31 : 11'sd255)) begin
         if (to_inf) res_in = (sign_ff ? sm : 32'd0) | (half_ff ? 32'h7c00 : 32'h7f800000);
         else res_in = (sign_ff ? sm : 32'd0) | (half_ff ? 32'h7bff : 32'h7f7fffff);
      end else if (half_ff)
         res_in = (sign_ff ? sm : 32'd0) | {17'd0, (nrm ? be[4:0] : 5'd0), qr[9:0]};
      else
         res_in = (sign_ff ? sm : 32'd0) | {1'b0, (nrm ? be[7:0] : 8'd0), qr[22:0]};
   end

   always_ff @(posedge clock) begin
      if (enable) res_ff <= res_in;
   end
endmodule
`default_nettype wire

// ===== rtl/float_multiply_rounded_top.sv =====
// Rounded IEEE multiplier, single or half format, four-stage pipeline.
// Four register stages: unpack, product, normalize, round and pack; rsp_tvalid is vld_ff[3].
// Throughput: one item per cycle;
// the whole pipe advances unless rsp is stalled.
// Reset (synchronous): clears all valid bits, format to single, rounding to nearest even.
// Depends on fmr_pkg, fmr_unpack, fmr_mult, fmr_round.
`default_nettype none
module float_multiply_rounded_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // product [31:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [1:0]  csr_data
);
   import fmr_pkg::*;
   logic fmt_ff;
   rnd_type rnd_ff;
   logic [3:0] vld_ff, vld_in;
   logic adv;
   unp_type unp;
   prd_type prd;

   assign adv = !vld_ff[3] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = vld_ff[3];
   assign vld_in = {vld_ff[2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         fmt_ff <= 1'b0;
         rnd_ff <= RND_NEAR;
      end else begin
         if (adv) vld_ff <= vld_in;
         if (csr_valid) begin
            if (csr_index == CSR_FORMAT) fmt_ff <= csr_data[0];
            else rnd_ff <= rnd_type'(csr_data);
         end
      end
   end

   fmr_unpack u_unpack (.clock(clock), .enable(adv), .half(fmt_ff), .rnd(rnd_ff),
      .operand_a(req_tdata[31:0]), .operand_b(req_tdata[63:32]), .unp_ff(unp));
   fmr_mult u_mult (.clock(clock), .enable(adv), .unp(unp), .prd_ff(prd));
   fmr_round u_round (.clock(clock), .enable(adv), .prd(prd), .res_ff(rsp_tdata));
endmodule
`default_nettype wire
